FILE: sv/dfr_pkg.sv
// ---------------------------------------------------------------------------
// Deframer package
// Shared types and constants for the sync/length frame deframer.
// ---------------------------------------------------------------------------
package dfr_pkg;

   localparam int unsigned DFR_MAX_PAYLOAD = 512;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FRAME_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_FLUSH_LIMIT = 1'd1;

   localparam logic [9:0] CSR_RESET_VALUE = 10'd512;
   localparam logic [9:0] TEXT_LIMIT_CAP  = 10'd512;

   localparam logic [7:0] SYNC_FIRST  = 8'h94;
   localparam logic [7:0] SYNC_SECOND = 8'hC3;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;

   localparam logic [1:0] KIND_TEXT     = 2'd0;
   localparam logic [1:0] KIND_LINE_END = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD  = 2'd2;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC1   = 3'd1,
      PH_LEN_HI  = 3'd2,
      PH_LEN_LO  = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] item_kind;
      logic [7:0] item_data;
      logic       item_last;
      logic [9:0] frame_length;
   } item_type;

endpackage

FILE: sv/dfr_req_if.sv
// ---------------------------------------------------------------------------
// Deframer request channel
// Valid/ready channel that carries one received byte per transaction.
// ---------------------------------------------------------------------------
interface dfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/dfr_rsp_if.sv
// ---------------------------------------------------------------------------
// Deframer response channel
// Valid/ready channel that carries one text, line-end or payload item.
// ---------------------------------------------------------------------------
interface dfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] item_kind;
   logic [7:0] item_data;
   logic       item_last;
   logic [9:0] frame_length;

   modport source (output valid, output item_kind, output item_data,
                   output item_last, output frame_length, input ready);
   modport sink   (input valid, input item_kind, input item_data,
                   input item_last, input frame_length, output ready);
endinterface

FILE: sv/dfr_parser.sv
// ---------------------------------------------------------------------------
// Deframer parser
// Parse state and the per-byte decision: one byte in, at most one item out.
// ---------------------------------------------------------------------------
module dfr_parser
   import dfr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = DFR_MAX_PAYLOAD
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  logic [9:0] max_frame_length,
   input  logic [9:0] text_flush_limit,
   output item_type   item
);

   localparam int unsigned PCW = $clog2(MAX_PAYLOAD + 1);
   localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);

   phase_type        phase_ff, phase_in;
   logic [15:0]      declared_ff, declared_in;
   logic [PCW-1:0]   payload_count_ff, payload_count_in;
   logic [9:0]       text_count_ff, text_count_in;

   logic [9:0]       text_next;
   logic [9:0]       text_limit;
   logic [PCW-1:0]   count_next;
   logic [15:0]      count_ext;
   logic [15:0]      cfg_max_ext;
   logic [15:0]      eff_max;
   logic [15:0]      length_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         declared_ff      <= '0;
         payload_count_ff <= '0;
         text_count_ff    <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         declared_ff      <= declared_in;
         payload_count_ff <= payload_count_in;
         text_count_ff    <= text_count_in;
      end
   end

   always_comb begin
      text_next   = text_count_ff + 10'd1;
      text_limit  = (text_flush_limit > TEXT_LIMIT_CAP) ? TEXT_LIMIT_CAP : text_flush_limit;
      count_next  = payload_count_ff + 1'b1;
      count_ext   = 16'(count_next);
      cfg_max_ext = 16'(max_frame_length);
      eff_max     = (cfg_max_ext > MAX_LEN16) ? MAX_LEN16 : cfg_max_ext;
      length_full = {declared_ff[15:8], rx_byte};

      phase_in         = phase_ff;
      declared_in      = declared_ff;
      payload_count_in = payload_count_ff;
      text_count_in    = text_count_ff;
      item             = '0;

      unique case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == SYNC_SECOND) begin
               phase_in = PH_LEN_HI;
            end else if (rx_byte != SYNC_FIRST) begin
               // Broken sync: the byte falls back to text without a flush check.
               phase_in = PH_HUNT;
               if (rx_byte != CH_CR && rx_byte != CH_LF) begin
                  text_count_in  = text_next;
                  item.valid     = 1'b1;
                  item.item_kind = KIND_TEXT;
                  item.item_data = rx_byte;
               end
            end
         end
         PH_LEN_HI: begin
            declared_in = {rx_byte, 8'h00};
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            declared_in = length_full;
            if (length_full == 16'd0 || length_full > eff_max) begin
               phase_in = PH_HUNT;
            end else begin
               payload_count_in = '0;
               phase_in         = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            payload_count_in  = count_next;
            item.valid        = 1'b1;
            item.item_kind    = KIND_PAYLOAD;
            item.item_data    = rx_byte;
            item.frame_length = declared_ff[9:0];
            if (count_ext >= declared_ff) begin
               item.item_last = 1'b1;
               phase_in       = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == SYNC_FIRST) begin
               phase_in = PH_SYNC1;
            end else if (rx_byte == CH_LF) begin
               if (text_count_ff != 10'd0) begin
                  text_count_in  = '0;
                  item.valid     = 1'b1;
                  item.item_kind = KIND_LINE_END;
               end
            end else if (rx_byte != CH_CR) begin
               item.valid     = 1'b1;
               item.item_kind = KIND_TEXT;
               item.item_data = rx_byte;
               if (text_next > text_limit) begin
                  text_count_in  = '0;
                  item.item_last = 1'b1;
               end else begin
                  text_count_in = text_next;
               end
            end
         end
      endcase
   end

endmodule

FILE: sv/sync_length_frame_deframer.sv
// ---------------------------------------------------------------------------
// Sync/length frame deframer
// Splits a received byte stream into framed payload bytes and text bytes.
// ---------------------------------------------------------------------------
//  Channel  Direction  Transaction
//  req_ch   in         one received byte (rx_byte)
//  rsp_ch   out        item_kind, item_data, item_last, frame_length
//  csr_*    in         register write: index 0 max length, 1 text flush limit
//
// Each byte passes an input register and then the parse logic into the
// result register; one byte per cycle while rsp_ch does not stall.
// A byte that yields no item still passes through the parse stage.
// Reset is synchronous; it clears the parse state and restores both
// registers to 512. When rsp_ch stalls, the input register holds one
// byte and req_ch.ready drops after that.
module sync_length_frame_deframer
   import dfr_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = DFR_MAX_PAYLOAD
) (
   input  logic                   clock,
   input  logic                   reset,
   dfr_req_if.sink                req_ch,
   dfr_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   item_type   rsp_item_ff;
   logic [9:0] max_len_ff;
   logic [9:0] flush_lim_ff;
   logic       advance;
   logic       req_accept;
   item_type   item;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_accept = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance ? item.valid : (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= CSR_RESET_VALUE;
         flush_lim_ff <= CSR_RESET_VALUE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_FRAME_LENGTH: max_len_ff   <= csr_wdata;
            CSR_TEXT_FLUSH_LIMIT: flush_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_ch.rx_byte;
      end
      if (advance && item.valid) begin
         rsp_item_ff <= item;
      end
   end

   dfr_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .rx_byte          (s1_byte_ff),
      .max_frame_length (max_len_ff),
      .text_flush_limit (flush_lim_ff),
      .item             (item)
   );

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.item_kind    = rsp_item_ff.item_kind;
   assign rsp_ch.item_data    = rsp_item_ff.item_data;
   assign rsp_ch.item_last    = rsp_item_ff.item_last;
   assign rsp_ch.frame_length = rsp_item_ff.frame_length;

endmodule

FILE: sv/dfr_checker.sv
// ---------------------------------------------------------------------------
// Deframer port checker
// Concurrent checks on the response port of the deframer, bound to the top.
// ---------------------------------------------------------------------------
module dfr_checker
   import dfr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] item_kind,
   input logic [7:0] item_data,
   input logic       item_last,
   input logic [9:0] frame_length
);

   // A stalled transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_kind) &&
      $stable(item_data) && $stable(item_last) && $stable(frame_length))
      else $error("response changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> item_kind == KIND_TEXT || item_kind == KIND_LINE_END ||
      item_kind == KIND_PAYLOAD)
      else $error("unknown item kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind == KIND_LINE_END |->
      item_data == 8'd0 && !item_last && frame_length == 10'd0)
      else $error("line end carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_kind == KIND_TEXT |-> frame_length == 10'd0)
      else $error("text item carries a frame length");

endmodule

bind sync_length_frame_deframer dfr_checker u_dfr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .item_kind    (rsp_ch.item_kind),
   .item_data    (rsp_ch.item_data),
   .item_last    (rsp_ch.item_last),
   .frame_length (rsp_ch.frame_length)
);

FILE: tb/sync_length_frame_deframer_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sync/length frame deframer testbench
// Drives received bytes through the request channel and checks every item on
// the response channel against a predicted item stream. The run covers both
// registers at several settings, framed and text traffic, and random gaps.
// ---------------------------------------------------------------------------
module sync_length_frame_deframer_test
   import dfr_pkg::*;
();

   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned STALL_LIMIT   = 1000;
   localparam int unsigned PHASE_COUNT   = 10;
   localparam int unsigned PHASE_BYTES   = 185;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic [9:0] flen;
   } deframer_item_type;

   // Tracks the parse state and holds the items that the bytes seen so far
   // must produce, oldest first.
   class deframed_items_type;
      phase_type         phase;
      logic [15:0]       decl_len;
      logic [15:0]       pay_count;
      logic [9:0]        text_count;
      logic [9:0]        max_len;
      logic [9:0]        flush_limit;
      deframer_item_type pending_items[$];
      int unsigned       mismatches;

      function new();
         phase       = PH_HUNT;
         decl_len    = '0;
         pay_count   = '0;
         text_count  = '0;
         max_len     = CSR_RESET_VALUE;
         flush_limit = CSR_RESET_VALUE;
         mismatches  = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] index, logic [9:0] value);
         if (index == CSR_MAX_FRAME_LENGTH)
            max_len = value;
         else if (index == CSR_TEXT_FLUSH_LIMIT)
            flush_limit = value;
      endfunction

      function void queue_item(logic [1:0] kind, logic [7:0] data, logic last,
                               logic [9:0] flen);
         pending_items.insert(pending_items.size(),
                              deframer_item_type'{kind, data, last, flen});
      endfunction

      function void take_byte(logic [7:0] b);
         int unsigned eff_max;
         int unsigned eff_limit;
         eff_max   = (max_len > DFR_MAX_PAYLOAD) ? DFR_MAX_PAYLOAD : max_len;
         eff_limit = (flush_limit > TEXT_LIMIT_CAP) ? TEXT_LIMIT_CAP : flush_limit;
         case (phase)
            PH_SYNC1: begin
               if (b == SYNC_SECOND) begin
                  phase = PH_LEN_HI;
               end else if (b != SYNC_FIRST) begin
                  // A broken sync byte falls back to text without a flush check.
                  phase = PH_HUNT;
                  if (b != CH_CR && b != CH_LF) begin
                     text_count = text_count + 10'd1;
                     queue_item(KIND_TEXT, b, 1'b0, 10'd0);
                  end
               end
            end
            PH_LEN_HI: begin
               decl_len = {b, 8'h00};
               phase    = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               decl_len = decl_len | {8'h00, b};
               if (decl_len == 16'd0 || decl_len > eff_max) begin
                  phase = PH_HUNT;
               end else begin
                  pay_count = '0;
                  phase     = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               pay_count = pay_count + 16'd1;
               if (pay_count >= decl_len) begin
                  phase = PH_HUNT;
                  queue_item(KIND_PAYLOAD, b, 1'b1, decl_len[9:0]);
               end else begin
                  queue_item(KIND_PAYLOAD, b, 1'b0, decl_len[9:0]);
               end
            end
            default: begin
               phase = PH_HUNT;
               if (b == SYNC_FIRST) begin
                  phase = PH_SYNC1;
               end else if (b == CH_LF) begin
                  if (text_count != 10'd0) begin
                     text_count = '0;
                     queue_item(KIND_LINE_END, 8'h00, 1'b0, 10'd0);
                  end
               end else if (b != CH_CR) begin
                  text_count = text_count + 10'd1;
                  if (text_count > eff_limit) begin
                     text_count = '0;
                     queue_item(KIND_TEXT, b, 1'b1, 10'd0);
                  end else begin
                     queue_item(KIND_TEXT, b, 1'b0, 10'd0);
                  end
               end
            end
         endcase
      endfunction

      function void match_item(deframer_item_type seen);
         deframer_item_type want;
         if (pending_items.size() == 0) begin
            $error("unexpected item: kind %0d, data 0x%02h, last %0d, length %0d",
                   seen.kind, seen.data, seen.last, seen.flen);
            mismatches++;
            return;
         end
         want = pending_items.pop_front();
         if (seen.kind !== want.kind) begin
            $error("item_kind: expected %0d, actual %0d", want.kind, seen.kind);
            mismatches++;
         end
         if (seen.data !== want.data) begin
            $error("item_data: expected 0x%02h, actual 0x%02h", want.data, seen.data);
            mismatches++;
         end
         if (seen.last !== want.last) begin
            $error("item_last: expected %0d, actual %0d", want.last, seen.last);
            mismatches++;
         end
         if (seen.flen !== want.flen) begin
            $error("frame_length: expected %0d, actual %0d", want.flen, seen.flen);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dfr_req_if req_if ();
   dfr_rsp_if rsp_if ();

   deframed_items_type rx_bytes = new();
   int unsigned        bytes_sent = 0;
   int unsigned        stall_cycles = 0;
   bit                 steady = 1'b0;

   sync_length_frame_deframer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Response side: check each accepted transaction, then pick the next ready.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         rx_bytes.match_item(deframer_item_type'{rsp_if.item_kind, rsp_if.item_data,
                                                 rsp_if.item_last, rsp_if.frame_length});
      rsp_if.ready <= steady || ($urandom_range(99) >= 10);
   end

   // Ends the run when neither channel has moved a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Returns at the edge where the byte is accepted, without driving anything
   // at that edge, so the caller may drive the next value.
   task automatic send_byte(input logic [7:0] value);
      while (!steady && $urandom_range(99) < 10) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      rx_bytes.take_byte(value);
      bytes_sent++;
   endtask

   // Holds the sender until every predicted item has come out, then lets the
   // pipeline empty of bytes that produce no item.
   task automatic settle_output();
      req_if.valid <= 1'b0;
      while (rx_bytes.pending_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [9:0] max_len, input logic [9:0] flush);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_FRAME_LENGTH;
      csr_wdata <= max_len;
      @(posedge clock);
      rx_bytes.set_reg(CSR_MAX_FRAME_LENGTH, max_len);
      csr_index <= CSR_TEXT_FLUSH_LIMIT;
      csr_wdata <= flush;
      @(posedge clock);
      rx_bytes.set_reg(CSR_TEXT_FLUSH_LIMIT, flush);
      csr_we <= 1'b0;
   endtask

   task automatic send_frame();
      int unsigned eff;
      int unsigned sel;
      logic [15:0] len;
      eff = (rx_bytes.max_len > DFR_MAX_PAYLOAD) ? DFR_MAX_PAYLOAD : rx_bytes.max_len;
      sel = $urandom_range(99);
      if (sel < 70)
         len = 16'($urandom_range(1, 12));
      else if (sel < 80)
         // Full-size frames are kept rare so that most items stay small.
         len = (eff > 64 && $urandom_range(7) != 0) ? 16'($urandom_range(1, 64)) : 16'(eff);
      else if (sel < 88)
         len = 16'(eff + 1);
      else if (sel < 92)
         len = 16'd0;
      else if (sel < 97)
         len = 16'($urandom_range(65535));
      else
         len = 16'hFFFF;
      if ($urandom_range(9) == 0)
         send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (len != 16'd0 && len <= eff)
         repeat (len) send_byte(8'($urandom_range(255)));
   endtask

   task automatic send_text();
      int unsigned cap;
      int unsigned count;
      int unsigned sel;
      bit          long_run;
      cap = (rx_bytes.flush_limit > TEXT_LIMIT_CAP) ? TEXT_LIMIT_CAP : rx_bytes.flush_limit;
      long_run = ($urandom_range(49) == 0);
      count = long_run ? cap + 2 : $urandom_range(1, 20);
      repeat (count) begin
         sel = $urandom_range(99);
         if (!long_run && sel < 8)
            send_byte(CH_LF);
         else if (!long_run && sel < 12)
            send_byte(CH_CR);
         else
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(4))
         0: begin
            send_byte(SYNC_FIRST);
            send_byte(8'($urandom_range(255)));
         end
         1: begin
            repeat ($urandom_range(1, 4)) send_byte(SYNC_FIRST);
            send_byte($urandom_range(1) ? CH_CR : CH_LF);
         end
         2: repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
         3: begin
            // A cut-off header: the next byte completes the length.
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            send_byte(8'($urandom_range(255)));
         end
         default: begin
            send_byte(CH_LF);
            send_byte(CH_LF);
         end
      endcase
   endtask

   task automatic run_random(input int unsigned quota);
      int unsigned stop_at;
      int unsigned sel;
      stop_at = bytes_sent + quota;
      while (bytes_sent < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 55)
            send_frame();
         else if (sel < 85)
            send_text();
         else
            send_noise();
         if ($urandom_range(39) == 0)
            settle_output();
      end
   endtask

   initial begin
      logic [7:0] directed_bytes [25];
      logic [9:0] max_cfg [PHASE_COUNT];
      logic [9:0] flush_cfg [PHASE_COUNT];

      directed_bytes = '{
         8'h41, 8'h00, 8'hFF, CH_CR, CH_LF, CH_LF,
         SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h01, 8'h5A,
         SYNC_FIRST, 8'h41,
         SYNC_FIRST, CH_LF,
         SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00,
         SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'hFF,
         CH_LF};
      max_cfg   = '{10'd512, 10'd1, 10'd0, 10'd1023, 10'd16,
                    10'd600, 10'd513, 10'd20, 10'd0, 10'd0};
      flush_cfg = '{10'd512, 10'd1, 10'd0, 10'd1023, 10'd8,
                    10'd700, 10'd513, 10'd0, 10'd0, 10'd0};
      max_cfg[8]   = 10'($urandom_range(1023));
      flush_cfg[8] = 10'($urandom_range(1023));
      max_cfg[9]   = 10'($urandom_range(1, 64));
      flush_cfg[9] = 10'($urandom_range(1, 64));

      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.rx_byte <= 8'h00;
      csr_we         <= 1'b0;
      csr_index      <= CSR_MAX_FRAME_LENGTH;
      csr_wdata      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed bytes at the reset settings.
      foreach (directed_bytes[i])
         send_byte(directed_bytes[i]);
      settle_output();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         steady = (p == 3);
         write_regs(max_cfg[p], flush_cfg[p]);
         run_random(PHASE_BYTES);
         settle_output();
      end

      if (rx_bytes.mismatches == 0 && rx_bytes.pending_items.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/dfr_pkg.sv
sv/dfr_req_if.sv
sv/dfr_rsp_if.sv
sv/dfr_parser.sv
sv/sync_length_frame_deframer.sv
sv/dfr_checker.sv
tb/sync_length_frame_deframer_test.sv
